FILE: src/ule_pkg.sv
// shared types and constants of the uart line editor
package ule_pkg;

  // request codes
  localparam logic [1:0] ReqChar = 2'd0;
  localparam logic [1:0] ReqAck  = 2'd1;
  localparam logic [1:0] ReqRead = 2'd2;

  // line status codes
  localparam logic [1:0] LineIdle  = 2'd0;
  localparam logic [1:0] LineEdit  = 2'd1;
  localparam logic [1:0] LineReady = 2'd2;

  // key and character codes
  localparam logic [7:0] KeyEnter     = 8'h0D;
  localparam logic [7:0] KeyBackspace = 8'h7F;
  localparam logic [7:0] CtrlLast     = 8'h1F;
  localparam logic [7:0] ChrCr        = 8'h0D;
  localparam logic [7:0] ChrSpace     = 8'h20;

  // request word
  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] rx_char;
    logic [3:0] read_index;
  } ule_in_t;

  // result word
  typedef struct packed {
    logic       has_char;
    logic [7:0] tx_char;
    logic       last;
    logic [1:0] line_state;
    logic [3:0] line_length;
    logic [7:0] read_data;
  } ule_out_t;

endpackage

FILE: src/uart_line_editor_unit.sv
// uart line editor top level: line store, edit sequencer and result register
// the result word for echo, enter and acknowledge is loaded in the cycle after accept;
// a read request passes the store read register, then the result register
// backspace on a line of n characters gives 2n+1 words, one per cycle while out_stall_i is low
// the next request is taken once the last result word of the previous one is loaded,
// the sequencer is back in idle and the result register is free to take a new word
// reset clears the sequencer, counts and line status; the line store has no reset
module uart_line_editor_unit #(
  parameter int BUFFER_SIZE = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  ule_pkg::ule_in_t in_word_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output ule_pkg::ule_out_t out_word_o
);

  localparam int AddrW = (BUFFER_SIZE > 1) ? $clog2(BUFFER_SIZE) : 1;
  localparam logic [3:0] LineCap = (BUFFER_SIZE - 1 > 15) ? 4'd15 : 4'(BUFFER_SIZE - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CR1,
    S_SPACE,
    S_CR2,
    S_CHAR,
    S_READ
  } state_e;

  // count to store address
  function automatic logic [AddrW-1:0] to_addr(input logic [3:0] v);
    logic [4:0] w;
    w = {1'b0, v};
    return w[AddrW-1:0];
  endfunction

  state_e            state_q, state_d;
  logic [1:0]        status_q, status_d;
  logic [3:0]        edit_q, edit_d;
  logic [3:0]        fin_q, fin_d;
  logic [3:0]        cnt_q, cnt_d;
  logic              hit_q, hit_d;
  logic              out_valid_q;
  ule_pkg::ule_out_t out_q;
  ule_pkg::ule_out_t item;

  logic [7:0]        mem [BUFFER_SIZE];
  logic [7:0]        rd_q;
  logic              rd_en, wr_en;
  logic [AddrW-1:0]  rd_addr, wr_addr;
  logic [7:0]        wr_data;

  logic              out_free, in_acc, emit;
  logic [3:0]        base, cnt_inc;
  logic              printable;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign cnt_inc    = cnt_q + 4'd1;
  assign base       = (status_q == ule_pkg::LineIdle) ? 4'd0 : edit_q;
  assign printable  = (in_word_i.rx_char > ule_pkg::CtrlLast) &&
                      (in_word_i.rx_char < ule_pkg::KeyBackspace);

  // sequencer next state and result word
  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    edit_d   = edit_q;
    fin_d    = fin_q;
    cnt_d    = cnt_q;
    hit_d    = hit_q;
    emit     = 1'b0;
    item     = '0;
    rd_en    = 1'b0;
    rd_addr  = '0;
    wr_en    = 1'b0;
    wr_addr  = to_addr(base);
    wr_data  = in_word_i.rx_char;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          emit      = 1'b1;
          item.last = 1'b1;
          unique case (in_word_i.req_type)
            ule_pkg::ReqChar: begin
              status_d = ule_pkg::LineEdit;
              edit_d   = base;
              if (in_word_i.rx_char == ule_pkg::KeyEnter) begin
                fin_d    = base;
                edit_d   = 4'd0;
                status_d = ule_pkg::LineReady;
              end else if (in_word_i.rx_char == ule_pkg::KeyBackspace) begin
                if (base != 4'd0) begin
                  edit_d  = base - 4'd1;
                  emit    = 1'b0;
                  state_d = S_CR1;
                end
              end else if (printable && (base < LineCap)) begin
                wr_en         = 1'b1;
                edit_d        = base + 4'd1;
                item.has_char = 1'b1;
                item.tx_char  = in_word_i.rx_char;
              end
            end
            ule_pkg::ReqAck: begin
              status_d = ule_pkg::LineIdle;
              edit_d   = 4'd0;
            end
            ule_pkg::ReqRead: begin
              emit    = 1'b0;
              rd_en   = 1'b1;
              rd_addr = to_addr(in_word_i.read_index);
              hit_d   = in_word_i.read_index < fin_q;
              state_d = S_READ;
            end
            default: ;
          endcase
        end
      end
      S_CR1: begin
        if (out_free) begin
          emit          = 1'b1;
          item.has_char = 1'b1;
          item.tx_char  = ule_pkg::ChrCr;
          cnt_d         = 4'd0;
          state_d       = S_SPACE;
        end
      end
      S_SPACE: begin
        // one space per character held before the deletion
        if (out_free) begin
          emit          = 1'b1;
          item.has_char = 1'b1;
          item.tx_char  = ule_pkg::ChrSpace;
          cnt_d         = cnt_inc;
          if (cnt_q == edit_q) state_d = S_CR2;
        end
      end
      S_CR2: begin
        if (out_free) begin
          emit          = 1'b1;
          item.has_char = 1'b1;
          item.tx_char  = ule_pkg::ChrCr;
          item.last     = (edit_q == 4'd0);
          cnt_d         = 4'd0;
          if (edit_q == 4'd0) begin
            state_d = S_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = '0;
            state_d = S_CHAR;
          end
        end
      end
      S_CHAR: begin
        // redraw the shortened line, next entry read ahead
        if (out_free) begin
          emit          = 1'b1;
          item.has_char = 1'b1;
          item.tx_char  = rd_q;
          item.last     = (cnt_inc == edit_q);
          rd_en         = 1'b1;
          rd_addr       = to_addr(cnt_inc);
          cnt_d         = cnt_inc;
          if (cnt_inc == edit_q) state_d = S_IDLE;
        end
      end
      S_READ: begin
        if (out_free) begin
          emit           = 1'b1;
          item.last      = 1'b1;
          item.read_data = hit_q ? rd_q : 8'd0;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    item.line_state  = status_d;
    item.line_length = (status_d == ule_pkg::LineReady) ? fin_d : edit_d;
  end

  // control state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      status_q    <= ule_pkg::LineIdle;
      edit_q      <= 4'd0;
      fin_q       <= 4'd0;
      cnt_q       <= 4'd0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      edit_q   <= edit_d;
      fin_q    <= fin_d;
      cnt_q    <= cnt_d;
      hit_q    <= hit_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (emit) out_q <= item;
  end

  // line store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

FILE: src/ule_checker.sv
// port checker for the uart line editor and its bind
module ule_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input ule_pkg::ule_in_t  in_word_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input ule_pkg::ule_out_t out_word_o
);

  // a stalled request word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_word_i))
    else $error("stalled request word changed");

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled result word changed");

  // a word without a character ends its request and carries no character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.has_char |-> out_word_o.last && out_word_o.tx_char == 8'd0)
    else $error("word without character is not last or has data");

  // nonzero read data only appears on a word without a character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.read_data != 8'd0 |-> !out_word_o.has_char)
    else $error("read data on a character word");

  // an idle line holds no characters
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.line_state == ule_pkg::LineIdle |->
      out_word_o.line_length == 4'd0)
    else $error("idle line with nonzero length");

endmodule

bind uart_line_editor_unit ule_checker u_ule_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

FILE: test/tb_top.sv
// self-checking testbench for the uart line editor unit
`timescale 1ns / 1ps

module tb_top;

  localparam int BufferSize = 16;
  localparam int LineCap = (BufferSize - 1 > 15) ? 15 : BufferSize - 1;
  localparam int RandomRequests = 270;
  localparam int HoldCycles = 400;
  localparam int WatchdogLimit = 3000;
  localparam int DrainCycles = 40;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall_o;
  ule_pkg::ule_in_t  in_word = '0;
  logic              out_valid_o;
  logic              out_stall = 1'b0;
  ule_pkg::ule_out_t out_word_o;

  // requests waiting to be sent, result words waiting to be seen
  ule_pkg::ule_in_t  requests_todo[$];
  ule_pkg::ule_out_t results_due[$];

  // shadow copy of the editor state
  logic [7:0] line_chars[BufferSize];
  logic [4:0] edit_count = '0;
  logic [4:0] finished_len = '0;
  logic [1:0] line_status = ule_pkg::LineIdle;

  int  words_in = 0;
  int  words_out = 0;
  int  mismatches = 0;
  int  redraws = 0;
  int  full_drops = 0;
  int  reads_done = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  int  quiet_cycles = 0;
  bit  hold_done = 1'b0;
  bit  calm = 1'b0;

  uart_line_editor_unit #(.BUFFER_SIZE(BufferSize)) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_word_o  (out_word_o)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // one result word built from the state after the request
  function automatic ule_pkg::ule_out_t result_word(input logic has, input logic [7:0] ch,
                                                    input logic [7:0] rd);
    ule_pkg::ule_out_t w;
    w.has_char    = has;
    w.tx_char     = ch;
    w.last        = 1'b0;
    w.line_state  = line_status;
    w.line_length = (line_status == ule_pkg::LineReady) ? finished_len[3:0]
                                                        : edit_count[3:0];
    w.read_data   = rd;
    return w;
  endfunction

  // expected words for one accepted request, appended to results_due
  function automatic void predict_editor(input ule_pkg::ule_in_t w);
    ule_pkg::ule_out_t words[$];
    logic [4:0]        old;
    logic [7:0]        rd;
    if (w.req_type == ule_pkg::ReqChar) begin
      if (line_status == ule_pkg::LineIdle) edit_count = '0;
      line_status = ule_pkg::LineEdit;
      if (w.rx_char == ule_pkg::KeyEnter) begin
        finished_len = edit_count;
        edit_count   = '0;
        line_status  = ule_pkg::LineReady;
        words.push_back(result_word(1'b0, 8'h00, 8'h00));
      end else if (w.rx_char == ule_pkg::KeyBackspace) begin
        if (edit_count > 0) begin
          // cr, blank the old line, cr, then the shortened line
          old        = edit_count;
          edit_count = old - 5'd1;
          redraws++;
          words.push_back(result_word(1'b1, ule_pkg::ChrCr, 8'h00));
          for (int j = 0; j < old; j++)
            words.push_back(result_word(1'b1, ule_pkg::ChrSpace, 8'h00));
          words.push_back(result_word(1'b1, ule_pkg::ChrCr, 8'h00));
          for (int j = 0; j < edit_count; j++)
            words.push_back(result_word(1'b1, line_chars[j], 8'h00));
        end else begin
          words.push_back(result_word(1'b0, 8'h00, 8'h00));
        end
      end else if (w.rx_char > ule_pkg::CtrlLast && w.rx_char < ule_pkg::KeyBackspace) begin
        if (edit_count < LineCap) begin
          line_chars[edit_count] = w.rx_char;
          edit_count = edit_count + 5'd1;
          words.push_back(result_word(1'b1, w.rx_char, 8'h00));
        end else begin
          full_drops++;
          words.push_back(result_word(1'b0, 8'h00, 8'h00));
        end
      end else begin
        words.push_back(result_word(1'b0, 8'h00, 8'h00));
      end
    end else if (w.req_type == ule_pkg::ReqAck) begin
      line_status = ule_pkg::LineIdle;
      edit_count  = '0;
      words.push_back(result_word(1'b0, 8'h00, 8'h00));
    end else if (w.req_type == ule_pkg::ReqRead) begin
      rd = (w.read_index < finished_len) ? line_chars[w.read_index] : 8'h00;
      reads_done++;
      words.push_back(result_word(1'b0, 8'h00, rd));
    end else begin
      words.push_back(result_word(1'b0, 8'h00, 8'h00));
    end
    words[words.size() - 1].last = 1'b1;
    foreach (words[k]) results_due.push_back(words[k]);
  endfunction

  // stimulus helpers, unused fields carry random bits
  task automatic send_req(input logic [1:0] kind, input logic [7:0] ch, input logic [3:0] idx);
    ule_pkg::ule_in_t w;
    w.req_type   = kind;
    w.rx_char    = ch;
    w.read_index = idx;
    requests_todo.push_back(w);
  endtask

  task automatic send_char(input logic [7:0] ch);
    send_req(ule_pkg::ReqChar, ch, 4'($urandom_range(0, 15)));
  endtask

  task automatic send_ack();
    send_req(ule_pkg::ReqAck, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
  endtask

  task automatic send_read(input logic [3:0] idx);
    send_req(ule_pkg::ReqRead, 8'($urandom_range(0, 255)), idx);
  endtask

  function automatic logic [7:0] printable_byte();
    return 8'($urandom_range(32, 126));
  endfunction

  // a byte the editor ignores: control or high byte other than enter
  function automatic logic [7:0] ignored_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if ((b > ule_pkg::CtrlLast && b <= ule_pkg::KeyBackspace) || b == ule_pkg::KeyEnter)
      b = b | 8'h80;
    return b;
  endfunction

  // a typed line with stray backspaces and noise, closed by enter
  task automatic type_line(input int n_chars);
    for (int k = 0; k < n_chars; k++) begin
      if ($urandom_range(0, 9) == 0) send_char(ule_pkg::KeyBackspace);
      if ($urandom_range(0, 19) == 0) send_char(ignored_byte());
      send_char(printable_byte());
    end
    send_char(ule_pkg::KeyEnter);
  endtask

  // stimulus and end of run
  initial begin
    int n_start;
    int len;

    // directed: edges of the byte ranges, every request, empty and idle cases
    send_read(4'd15);
    send_char(ule_pkg::KeyBackspace);
    send_char(8'h00);
    send_char(ule_pkg::CtrlLast);
    send_char(8'h20);
    send_char(8'h7E);
    send_char(8'h80);
    send_char(8'hFF);
    send_char(ule_pkg::KeyBackspace);
    send_char(8'h41);
    send_char(ule_pkg::KeyEnter);
    send_read(4'd0);
    send_read(4'd1);
    send_read(4'd2);
    send_read(4'd15);
    send_ack();
    send_read(4'd1);
    send_char(ule_pkg::KeyEnter);
    send_ack();
    send_char(8'h61);
    send_ack();
    send_char(ule_pkg::KeyBackspace);

    // overfill a line, then backspace on the full line and redraw it
    for (int k = 0; k < 17; k++) send_char(printable_byte());
    send_char(ule_pkg::KeyBackspace);
    send_char(ule_pkg::KeyEnter);
    send_read(4'd13);
    send_read(4'd14);
    send_ack();

    // random: mostly whole lines with reads and acks, some loose requests
    n_start = requests_todo.size();
    while (requests_todo.size() - n_start < RandomRequests) begin
      if ($urandom_range(0, 9) < 7) begin
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(12, 17) : $urandom_range(0, 8);
        type_line(len);
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 1) == 0) send_read(4'($urandom_range(0, len)));
          else send_read(4'($urandom_range(0, 15)));
        end
        if ($urandom_range(0, 3) != 0) send_ack();
      end else begin
        repeat ($urandom_range(1, 4))
          send_req(2'($urandom_range(0, 2)), 8'($urandom_range(0, 255)),
                   4'($urandom_range(0, 15)));
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (requests_todo.size() != 0 || in_valid) @(posedge clk_i);
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("run covered %0d requests and %0d result words: %0d redraws, %0d reads,",
             words_in, words_out, redraws, reads_done);
    $display("%0d characters dropped on a full line, one receiver hold of %0d cycles",
             full_drops, HoldCycles);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // request driver with random idle bursts
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      calm     <= 1'b0;
    end else begin
      calm <= (requests_todo.size() < 40) || (words_in >= 150 && words_in < 200);
      if (in_valid && !in_stall_o) begin
        predict_editor(in_word);
        words_in <= words_in + 1;
      end
      if (!in_valid || !in_stall_o) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (!calm && hold_left == 0 && in_valid && $urandom_range(0, 7) == 0) begin
          in_valid <= 1'b0;
          gap_left <= $urandom_range(0, 17);
        end else if (requests_todo.size() != 0) begin
          in_valid <= 1'b1;
          in_word  <= requests_todo.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall: random bursts plus one long hold to back the block up
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && words_in >= 60) begin
      hold_done <= 1'b1;
      hold_left <= HoldCycles - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 17);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic check_field(input string name, input logic [7:0] exp, input logic [7:0] act);
    if (exp !== act) begin
      $display("%0t: mismatch on %s, expected %0h, got %0h", $time, name, exp, act);
      mismatches++;
    end
  endtask

  // result monitor
  always @(posedge clk_i) begin
    ule_pkg::ule_out_t exp;
    if (rst_ni && out_valid_o && !out_stall) begin
      words_out <= words_out + 1;
      if (results_due.size() == 0) begin
        $display("%0t: unexpected word, expected none, got %h", $time, out_word_o);
        mismatches++;
      end else begin
        exp = results_due.pop_front();
        check_field("has_char", 8'(exp.has_char), 8'(out_word_o.has_char));
        check_field("tx_char", exp.tx_char, out_word_o.tx_char);
        check_field("last", 8'(exp.last), 8'(out_word_o.last));
        check_field("line_state", 8'(exp.line_state), 8'(out_word_o.line_state));
        check_field("line_length", 8'(exp.line_length), 8'(out_word_o.line_length));
        check_field("read_data", exp.read_data, out_word_o.read_data);
      end
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: timeout, %0d words still expected", $time, results_due.size());
        $display("end of test: mismatches");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule
